>>> rtl/core/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg: shared types and constants of the feedback FM resonator
// Register codes, field widths, controller-to-datapath command word and
// saturation helpers for the Q8.23 state and the Q1.23 output.
// ----------------------------------------------------------------------------
package ffr_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int SAMPLE_W  = 24;
	localparam int STATE_W   = 32;
	localparam int BASE_W    = 32;
	localparam int COEFF_W   = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_COEFF = 8'd1;

	localparam logic [BASE_W-1:0]         BASE_STEP_RST = 32'd67979299;
	localparam logic signed [COEFF_W-1:0] FEEDBACK_RST  = 16'sd3686;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam logic [SAMPLE_W-1:0] ONE_Q23 = 24'd8388608;

	// Datapath operation issued by the controller in each cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_MUL_M,
		OP_FACTOR,
		OP_MUL_PLO,
		OP_MUL_PHI,
		OP_PHASE,
		OP_MUL_IDX,
		OP_READ_I,
		OP_READ_J,
		OP_SINCOS,
		OP_MUL_CR,
		OP_MUL_SI,
		OP_MUL_CI,
		OP_MUL_SR,
		OP_UPDATE
	} ffr_op_t;

	typedef struct packed {
		ffr_op_t op;
		logic    fill_we;
	} ffr_cmd_t;

	// Clamp a 36-bit value to the signed 32-bit state range
	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [35:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	// Clamp a 36-bit value to the signed Q1.23 sample range
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [35:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 36'sd8388607) begin
			r = 24'sh7F_FFFF;
		end else if (v < -36'sd8388608) begin
			r = 24'sh80_0000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/ffr_ram.sv
// ----------------------------------------------------------------------------
// ffr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ffr_ctrl.sv
// ----------------------------------------------------------------------------
// ffr_ctrl: sequencer of the feedback FM resonator
// Runs the table fill after reset, then steps each sample through the
// shared multiplier and owns the input stall and output valid.
// ----------------------------------------------------------------------------
module ffr_ctrl #(
	parameter int SINE_TABLE_DEPTH = ffr_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ffr_pkg::ffr_cmd_t                   cmd,
	output logic [$clog2(SINE_TABLE_DEPTH)-1:0] fill_addr
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam logic [AW-1:0] FILL_LAST = AW'(SINE_TABLE_DEPTH - 1);

	typedef enum logic [15:0] {
		ST_FILL = 16'h0001,
		ST_IDLE = 16'h0002,
		ST_M    = 16'h0004,
		ST_FAC  = 16'h0008,
		ST_PLO  = 16'h0010,
		ST_PHI  = 16'h0020,
		ST_PH   = 16'h0040,
		ST_IDX  = 16'h0080,
		ST_RD0  = 16'h0100,
		ST_RD1  = 16'h0200,
		ST_CS   = 16'h0400,
		ST_P1   = 16'h0800,
		ST_P2   = 16'h1000,
		ST_P3   = 16'h2000,
		ST_P4   = 16'h4000,
		ST_UPD  = 16'h8000
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;
	logic          load_out;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d     = state_q;
		cmd.op      = ffr_pkg::OP_NONE;
		cmd.fill_we = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_FILL: begin
				cmd.fill_we = 1'b1;
				if (cnt_q == FILL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = ffr_pkg::OP_LOAD_IN;
					state_d = ST_M;
				end
			end
			ST_M:   begin cmd.op = ffr_pkg::OP_MUL_M;   state_d = ST_FAC; end
			ST_FAC: begin cmd.op = ffr_pkg::OP_FACTOR;  state_d = ST_PLO; end
			ST_PLO: begin cmd.op = ffr_pkg::OP_MUL_PLO; state_d = ST_PHI; end
			ST_PHI: begin cmd.op = ffr_pkg::OP_MUL_PHI; state_d = ST_PH;  end
			ST_PH:  begin cmd.op = ffr_pkg::OP_PHASE;   state_d = ST_IDX; end
			ST_IDX: begin cmd.op = ffr_pkg::OP_MUL_IDX; state_d = ST_RD0; end
			ST_RD0: begin cmd.op = ffr_pkg::OP_READ_I;  state_d = ST_RD1; end
			ST_RD1: begin cmd.op = ffr_pkg::OP_READ_J;  state_d = ST_CS;  end
			ST_CS:  begin cmd.op = ffr_pkg::OP_SINCOS;  state_d = ST_P1;  end
			ST_P1:  begin cmd.op = ffr_pkg::OP_MUL_CR;  state_d = ST_P2;  end
			ST_P2:  begin cmd.op = ffr_pkg::OP_MUL_SI;  state_d = ST_P3;  end
			ST_P3:  begin cmd.op = ffr_pkg::OP_MUL_CI;  state_d = ST_P4;  end
			ST_P4:  begin cmd.op = ffr_pkg::OP_MUL_SR;  state_d = ST_UPD; end
			ST_UPD: begin
				// hold here until the output register can take the word
				if (out_free) begin
					cmd.op   = ffr_pkg::OP_UPDATE;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign fill_addr = cnt_q;

endmodule

>>> rtl/core/ffr_dp.sv
// ----------------------------------------------------------------------------
// ffr_dp: datapath of the feedback FM resonator
// Config registers, complex state, one shared signed multiplier, the
// quarter-wave sine RAM with its fill source, and the output register.
// ----------------------------------------------------------------------------
module ffr_dp #(
	parameter int SINE_TABLE_DEPTH = ffr_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_wr_en,
	input  logic [ffr_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [ffr_pkg::CFG_DATA_W-1:0]             cfg_wdata,
	input  logic signed [ffr_pkg::SAMPLE_W-1:0]        in_sample,
	input  ffr_pkg::ffr_cmd_t                          cmd,
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]        fill_addr,
	output logic signed [ffr_pkg::SAMPLE_W-1:0]        out_sample
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam logic [AW:0] DEPTH_V = (AW+1)'(SINE_TABLE_DEPTH);
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Taylor series divisors (n+1)(n+2) for n = 1, 3, 5, ...
	localparam longint TAYLOR_DIV [20] = '{
		6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
		506, 600, 702, 812, 930, 1056, 1190, 1332, 1482, 1640
	};

	typedef logic [ffr_pkg::SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t   r;
		longint x, x2, term, sum;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x    = (longint'(k) * ffr_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2   = (x * x) >>> 30;
			term = x;
			sum  = 0;
			for (int it = 0; it < 20; it++) begin
				if ((it % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
				term = ((term * x2) >>> 30) / TAYLOR_DIV[it];
			end
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 64) >>> 7;
			if (sum > 64'sd8388607) begin
				sum = 64'sd8388607;
			end
			r[k] = ffr_pkg::SAMPLE_W'(sum);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// config
	logic [ffr_pkg::BASE_W-1:0]         base_step_q;
	logic signed [ffr_pkg::COEFF_W-1:0] feedback_coeff_q;

	// state and working registers
	logic signed [ffr_pkg::STATE_W-1:0]  re_prev_q, im_prev_q;
	logic signed [ffr_pkg::SAMPLE_W-1:0] smp_q;
	logic signed [64:0]                  prod_q;
	logic signed [57:0]                  acc_q, racc_q;
	logic signed [36:0]                  factor_q;
	logic [31:0]                         phase_q;
	logic [AW-1:0]                       i_q;
	logic                                jfull_q;
	logic [ffr_pkg::SAMPLE_W-1:0]        li_q;
	logic signed [24:0]                  c_q, s_q;
	logic signed [ffr_pkg::SAMPLE_W-1:0] out_q;

	// fill path
	logic [ffr_pkg::SAMPLE_W-1:0] rom_s1;
	logic [AW-1:0]                waddr_s1;
	logic                         we_s1;

	// combinational
	logic signed [32:0]           mul_a;
	logic signed [31:0]           mul_b;
	logic                         mul_en;
	logic signed [64:0]           mul_p;
	logic signed [35:0]           m_val;
	logic [54:0]                  phase_sum;
	logic [AW:0]                  j_full;
	logic [AW-1:0]                raddr;
	logic [ffr_pkg::SAMPLE_W-1:0] rdata;
	logic [ffr_pkg::SAMPLE_W-1:0] lj;
	logic signed [24:0]           li_pos, lj_pos;
	logic signed [57:0]           im_sum;
	logic signed [35:0]           re_full, im_full;
	logic signed [ffr_pkg::STATE_W-1:0] re_new;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			ffr_pkg::OP_MUL_M: begin
				mul_a = 33'(feedback_coeff_q);
				mul_b = re_prev_q;
			end
			ffr_pkg::OP_MUL_PLO: begin
				mul_a = $signed({1'b0, base_step_q});
				mul_b = $signed({13'd0, factor_q[18:0]});
			end
			ffr_pkg::OP_MUL_PHI: begin
				mul_a = $signed({1'b0, base_step_q});
				mul_b = 32'($signed(factor_q[36:19]));
			end
			ffr_pkg::OP_MUL_IDX: begin
				mul_a = $signed({3'd0, phase_q[29:0]});
				mul_b = 32'(SINE_TABLE_DEPTH);
			end
			ffr_pkg::OP_MUL_CR: begin
				mul_a = 33'(c_q);
				mul_b = re_prev_q;
			end
			ffr_pkg::OP_MUL_SI: begin
				mul_a = 33'(s_q);
				mul_b = im_prev_q;
			end
			ffr_pkg::OP_MUL_CI: begin
				mul_a = 33'(c_q);
				mul_b = im_prev_q;
			end
			ffr_pkg::OP_MUL_SR: begin
				mul_a = 33'(s_q);
				mul_b = re_prev_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// floor(coeff * re / 2^12)
	assign m_val = prod_q[47:12];
	// low partial product plus high partial product shifted by 19
	assign phase_sum = acc_q[54:0] + {prod_q[35:0], 19'd0};
	assign j_full = DEPTH_V - {1'b0, i_q};

	always_comb begin
		case (cmd.op)
			ffr_pkg::OP_READ_I: raddr = prod_q[30 +: AW];
			ffr_pkg::OP_READ_J: raddr = j_full[AW-1:0];
			default:            raddr = i_q;
		endcase
	end

	// table position D reads as one
	assign lj     = jfull_q ? ffr_pkg::ONE_Q23 : rdata;
	assign li_pos = $signed({1'b0, li_q});
	assign lj_pos = $signed({1'b0, lj});

	assign im_sum  = acc_q + $signed(prod_q[57:0]);
	assign re_full = {racc_q[57], racc_q[57:23]} + {{12{smp_q[23]}}, smp_q};
	assign im_full = {im_sum[57], im_sum[57:23]};
	assign re_new  = ffr_pkg::sat_state(re_full);

	ffr_ram #(
		.WIDTH (ffr_pkg::SAMPLE_W),
		.DEPTH (SINE_TABLE_DEPTH)
	) u_sine_ram (
		.clk   (clk),
		.we    (we_s1),
		.waddr (waddr_s1),
		.wdata (rom_s1),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q      <= ffr_pkg::BASE_STEP_RST;
			feedback_coeff_q <= ffr_pkg::FEEDBACK_RST;
			re_prev_q        <= '0;
			im_prev_q        <= '0;
			we_s1            <= 1'b0;
		end else begin
			we_s1 <= cmd.fill_we;
			if (cfg_wr_en) begin
				if (cfg_index == ffr_pkg::REG_BASE_STEP) begin
					base_step_q <= cfg_wdata;
				end else if (cfg_index == ffr_pkg::REG_FEEDBACK_COEFF) begin
					feedback_coeff_q <= cfg_wdata[ffr_pkg::COEFF_W-1:0];
				end
			end
			if (cmd.op == ffr_pkg::OP_UPDATE) begin
				re_prev_q <= re_new;
				im_prev_q <= ffr_pkg::sat_state(im_full);
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_s1   <= SINE_ROM[fill_addr];
		waddr_s1 <= fill_addr;
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (cmd.op)
			ffr_pkg::OP_LOAD_IN: smp_q <= in_sample;
			ffr_pkg::OP_FACTOR:  factor_q <= {m_val[35], m_val} + 37'sd8388608;
			ffr_pkg::OP_MUL_PHI: acc_q <= $signed(prod_q[57:0]);
			ffr_pkg::OP_PHASE:   phase_q <= phase_sum[54:23];
			ffr_pkg::OP_READ_I:  i_q <= prod_q[30 +: AW];
			ffr_pkg::OP_READ_J: begin
				li_q    <= rdata;
				jfull_q <= (i_q == '0);
			end
			ffr_pkg::OP_SINCOS: begin
				case (phase_q[31:30])
					QUAD_0: begin s_q <= li_pos;  c_q <= lj_pos;  end
					QUAD_1: begin s_q <= lj_pos;  c_q <= -li_pos; end
					QUAD_2: begin s_q <= -li_pos; c_q <= -lj_pos; end
					QUAD_3: begin s_q <= -lj_pos; c_q <= li_pos;  end
					default: begin s_q <= li_pos; c_q <= lj_pos;  end
				endcase
			end
			ffr_pkg::OP_MUL_SI:  acc_q <= $signed(prod_q[57:0]);
			ffr_pkg::OP_MUL_CI:  racc_q <= acc_q - $signed(prod_q[57:0]);
			ffr_pkg::OP_MUL_SR:  acc_q <= $signed(prod_q[57:0]);
			ffr_pkg::OP_UPDATE:  out_q <= ffr_pkg::sat_sample(re_full);
			default: begin
			end
		endcase
	end

	assign out_sample = out_q;

endmodule

>>> rtl/core/feedback_fm_complex_resonator.sv
// ----------------------------------------------------------------------------
// feedback_fm_complex_resonator: feedback FM complex one-pole resonator
// Rotates a complex Q8.23 state by a phase modulated by its own real part.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one Q1.23 sample
//   per word; a word is taken on a rising edge with valid high, stall low.
//   Output channel (out_valid / out_stall / out_sample) delivers the new
//   real part, saturated to Q1.23, one word per input word, in order.
//   Config port: cfg_wr_en with cfg_index 0 writes base_step, index 1
//   writes feedback_coeff (low 16 bits); other indexes are dropped. Write
//   only while no sample is in flight.
//   Result: out_valid rises as the sequencer leaves its final update step.
//   Pacing: in_stall stays high while a word is worked on, as the single
//   shared multiplier is stepped by the sequencer through eight products
//   (table index included) plus the phase and two sine table reads.
//   Reset: config returns to its defaults, state clears to zero, and the
//   quarter-wave sine RAM is filled from the constant table; in_stall
//   stays high while the fill sweep runs.
//   Receiver stall: the finished word waits in the output register while
//   the next sample is taken and processed; the sequencer holds on its
//   final step until that register frees up.
// ----------------------------------------------------------------------------
module feedback_fm_complex_resonator #(
	parameter int SINE_TABLE_DEPTH = ffr_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ffr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ffr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ffr_pkg::SAMPLE_W-1:0] in_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ffr_pkg::SAMPLE_W-1:0] out_sample
);

	// command word from the sequencer to the datapath
	ffr_pkg::ffr_cmd_t                   cmd;
	// fill address for the sine RAM sweep after reset
	logic [$clog2(SINE_TABLE_DEPTH)-1:0] fill_addr;

	// Sequencer: fill sweep, per-sample step order, handshake control
	ffr_ctrl #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.fill_addr (fill_addr)
	);

	// Datapath: registers, shared multiplier, sine RAM, output word
	ffr_dp #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_sample  (in_sample),
		.cmd        (cmd),
		.fill_addr  (fill_addr),
		.out_sample (out_sample)
	);

endmodule

>>> rtl/core/ffr_checker.sv
// ----------------------------------------------------------------------------
// ffr_checker: port-level checks of the feedback FM resonator
// Watches the handshakes and the sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module ffr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [ffr_pkg::SAMPLE_W-1:0] out_sample
);

	// a stalled output word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_sample))
		else $error("output word changed while stalled");

	// a taken sample keeps the input closed through the first steps of its work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input reopened too early");

	// a new result appears only as the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while sequencer busy");

endmodule

bind feedback_fm_complex_resonator ffr_checker u_ffr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_sample (out_sample)
);
